// ===== src/xml_entity_unescape_core_macros.svh =====
// Assertion macros shared by the unescaper RTL.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef XML_ENTITY_UNESCAPE_CORE_MACROS_SVH
`define XML_ENTITY_UNESCAPE_CORE_MACROS_SVH

`ifndef SYNTH
// checked while out of reset
`define XEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define XEU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XEU_ASSERT(lbl, prop, msg)
`define XEU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/xeu_pkg.sv =====
// Package for the XML entity unescaper: sizes, entity name table, shared types.
// No dependencies.
package xeu_pkg;

  localparam int MAX_HELD      = 4;
  localparam int RUN_LEN       = MAX_HELD + 2;
  localparam int CNT_W         = $clog2(MAX_HELD + 1);
  localparam int HIDX_W        = $clog2(MAX_HELD);
  localparam int RUN_W         = $clog2(RUN_LEN + 1);
  localparam int NUM_NAMES     = 5;
  localparam int NAME_MAX_LEN  = 5;

  localparam logic [7:0] AMP_BYTE = 8'h26;

  // name bytes after the ampersand, semicolon included
  localparam logic [7:0] NAME_STR [NUM_NAMES][NAME_MAX_LEN] = '{
    '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // lt;
    '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // gt;
    '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // amp;
    '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},   // quot;
    '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}    // apos;
  };
  localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
  localparam logic [7:0] NAME_CH  [NUM_NAMES] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

  typedef logic [MAX_HELD-1:0][7:0] held_vec_t;

  typedef struct packed {
    logic       full;     // byte completes an entity
    logic       prefix;   // byte extends a proper prefix
    logic [7:0] ch;       // decoded character on a full match
  } match_t;

  typedef struct packed {
    logic [RUN_LEN-1:0][7:0] bytes;   // word 0 goes out first
    logic [RUN_W-1:0]        len;
    logic                    text_last;
  } run_t;

endpackage

// ===== src/xeu_in_if.sv =====
// Input byte channel of the XML entity unescaper.
// No dependencies.
interface xeu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== src/xeu_out_if.sv =====
// Result byte channel of the XML entity unescaper.
// No dependencies.
interface xeu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_last;

  modport source (output valid, output out_byte, output run_last, output text_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_last,
                  output ready);
endinterface

// ===== src/xeu_match.sv =====
// Entity name matcher: classifies the incoming byte against the held prefix.
// Depends on xeu_pkg.
module xeu_match (
  input  xeu_pkg::held_vec_t        held_bytes,
  input  logic [xeu_pkg::CNT_W-1:0] held_count,
  input  logic [7:0]                text_byte,
  output xeu_pkg::match_t           result
);
  import xeu_pkg::*;

  always_comb begin
    logic       ok;
    logic [7:0] nb;
    result = '0;
    // descending so the first name in table order wins
    for (int k = NUM_NAMES - 1; k >= 0; k--) begin
      ok = (int'(held_count) + 1 <= int'(NAME_LEN[k]));
      for (int i = 0; i < NAME_MAX_LEN - 1; i++) begin
        if ((int'(held_count) > i) && (held_bytes[i] != NAME_STR[k][i])) begin
          ok = 1'b0;
        end
      end
      nb = 8'h00;
      for (int j = 0; j < NAME_MAX_LEN; j++) begin
        if (int'(held_count) == j) begin
          nb = NAME_STR[k][j];
        end
      end
      if (ok && (nb == text_byte)) begin
        result.full   = (int'(held_count) + 1 == int'(NAME_LEN[k]));
        result.prefix = (int'(held_count) + 1 != int'(NAME_LEN[k]));
        result.ch     = NAME_CH[k];
      end
    end
  end

endmodule

// ===== src/xeu_state.sv =====
// Match state (pending ampersand, held bytes) and per-word run builder.
// Depends on xeu_pkg, xeu_match and the assertion macro header.
`include "xml_entity_unescape_core_macros.svh"

module xeu_state (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  output xeu_pkg::run_t run
);
  import xeu_pkg::*;

  logic              in_entity_r, in_entity_nxt;
  logic [CNT_W-1:0]  held_count_r, held_count_nxt;
  held_vec_t         held_r;
  match_t            m;
  logic              hold, flush, emit_c, pre;
  logic [7:0]        last_byte;

  xeu_match u_match (
    .held_bytes (held_r),
    .held_count (held_count_r),
    .text_byte  (text_byte),
    .result     (m)
  );

  assign hold      = in_entity_r && m.prefix && (held_count_r < CNT_W'(MAX_HELD));
  assign flush     = in_entity_r && !m.full && !hold;
  assign emit_c    = (text_byte != AMP_BYTE) || end_of_text;
  assign pre       = flush || (hold && end_of_text);
  assign last_byte = (in_entity_r && m.full) ? m.ch : text_byte;

  // flush layout: '&', held bytes, then the byte; else just word 0
  always_comb begin
    run.bytes     = {8'h00, held_r, AMP_BYTE};
    run.text_last = end_of_text;
    for (int j = 1; j < RUN_LEN; j++) begin
      if (RUN_W'(j) == RUN_W'(held_count_r) + RUN_W'(1)) begin
        run.bytes[j] = last_byte;
      end
    end
    if (!pre) begin
      run.bytes[0] = last_byte;
    end
    priority if (!in_entity_r) begin
      run.len = emit_c ? RUN_W'(1) : '0;
    end else if (m.full) begin
      run.len = RUN_W'(1);
    end else if (hold) begin
      run.len = end_of_text ? RUN_W'(held_count_r) + RUN_W'(2) : '0;
    end else begin
      run.len = RUN_W'(held_count_r) + RUN_W'(1) + RUN_W'(emit_c);
    end
  end

  always_comb begin
    in_entity_nxt  = in_entity_r;
    held_count_nxt = held_count_r;
    priority if (!in_entity_r) begin
      in_entity_nxt  = (text_byte == AMP_BYTE);
      held_count_nxt = '0;
    end else if (m.full) begin
      in_entity_nxt  = 1'b0;
      held_count_nxt = '0;
    end else if (hold) begin
      held_count_nxt = held_count_r + CNT_W'(1);
    end else begin
      in_entity_nxt  = (text_byte == AMP_BYTE);
      held_count_nxt = '0;
    end
    if (end_of_text) begin
      in_entity_nxt  = 1'b0;
      held_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_entity_r  <= 1'b0;
      held_count_r <= '0;
    end else if (fire) begin
      in_entity_r  <= in_entity_nxt;
      held_count_r <= held_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hold) begin
      held_r[held_count_r[HIDX_W-1:0]] <= text_byte;
    end
  end

  `XEU_ASSERT(a_held_max, held_count_r <= CNT_W'(MAX_HELD), "held count overflow")
  `XEU_ASSERT(a_idle_empty, !in_entity_r |-> held_count_r == '0, "held bytes while idle")
  `XEU_ASSERT(a_eot_clears, fire && end_of_text |=> !in_entity_r, "pending after end of text")

endmodule

// ===== src/xeu_emit.sv =====
// Result register: holds one run, shifts one word out per cycle when ready.
// Depends on xeu_pkg, xeu_out_if and the assertion macro header.
`include "xml_entity_unescape_core_macros.svh"

module xeu_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  xeu_pkg::run_t run,
  output logic          in_rdy,
  xeu_out_if.source     out_ch
);
  import xeu_pkg::*;

  logic [RUN_LEN-1:0][7:0] buf_r, buf_nxt;
  logic [RUN_W-1:0]        cnt_r, cnt_nxt;
  logic                    tl_r, tl_nxt;
  logic                    pop, load;

  assign out_ch.valid     = (cnt_r != '0);
  assign out_ch.out_byte  = buf_r[0];
  assign out_ch.run_last  = (cnt_r == RUN_W'(1));
  assign out_ch.text_last = tl_r && (cnt_r == RUN_W'(1));

  // a new run may enter as the final word of the current one leaves
  assign in_rdy = (cnt_r == '0) || ((cnt_r == RUN_W'(1)) && out_ch.ready);
  assign pop    = out_ch.valid && out_ch.ready;
  assign load   = fire && (run.len != '0);

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    tl_nxt  = tl_r;
    if (load) begin
      buf_nxt = run.bytes;
      cnt_nxt = run.len;
      tl_nxt  = run.text_last;
    end else if (pop) begin
      buf_nxt = {8'h00, buf_r[RUN_LEN-1:1]};
      cnt_nxt = cnt_r - RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tl_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      tl_r  <= tl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  `XEU_ASSERT(a_cnt_range, cnt_r <= RUN_W'(RUN_LEN), "run length out of range")
  `XEU_ASSERT(a_run_cont, pop && !out_ch.run_last |=> out_ch.valid, "run broken")
  `XEU_ASSERT(a_load_len, load |=> cnt_r == $past(run.len), "run not loaded")

endmodule

// ===== src/xml_entity_unescape_core.sv =====
// XML predefined-entity unescaper, top level.
// Input channel in_ch: one text byte per word with end_of_text on the last
// byte of a text. Output channel out_ch: unescaped bytes; run_last marks the
// final word caused by one input word, text_last the final word of a text.
// "&lt;" "&gt;" "&amp;" "&quot;" "&apos;" become one character; a broken
// entity comes out unchanged, and a pending one is flushed at end of text.
// Latency: the first word caused by an input word is valid the cycle after
// it is accepted. Throughput: one input word per cycle while out_ch is
// ready and each yields at most one word; a word that yields k words (up
// to 6, a flushed run) holds in_ch.ready low until the last is taken.
// Words that only extend a held prefix yield nothing.
// The output run register is what paces the channel.
// Reset (rst_n low, synchronous): no pending ampersand, output empty.
// When out_ch stalls, the current word holds and in_ch.ready stays low
// unless the output is empty.
// Depends on xeu_pkg, xeu_in_if, xeu_out_if, xeu_state and xeu_emit.
module xml_entity_unescape_core (
  input  logic      clk,
  input  logic      rst_n,
  xeu_in_if.sink    in_ch,
  xeu_out_if.source out_ch
);
  import xeu_pkg::*;

  logic in_rdy;
  logic fire;
  run_t run;

  assign in_ch.ready = in_rdy;
  assign fire        = in_ch.valid && in_rdy;

  xeu_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .text_byte   (in_ch.text_byte),
    .end_of_text (in_ch.end_of_text),
    .run         (run)
  );

  xeu_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .run    (run),
    .in_rdy (in_rdy),
    .out_ch (out_ch)
  );

endmodule
